// ----- hw/rtl/sha256_stream_hasher_macros.svh -----
// Assertion macros for the SHA-256 stream hasher.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SHA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SHA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/sha_pkg.sv -----
// Shared types, constants and functions of the SHA-256 stream hasher.
package sha_pkg;
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_END  = 1'b1;
    localparam int   QDEPTH    = 4;

    typedef struct packed {
        logic       func;
        logic [7:0] data;
    } t_req;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage

// ----- hw/rtl/sha_front.sv -----
// Front end: accepts requests and queues them for the engine.
module sha_front import sha_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_req       i_req,
    output logic       o_valid,
    input  logic       i_ready,
    output t_req       o_req
);
    localparam int AW = $clog2(QDEPTH);
    t_req          r_mem [QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != (AW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end
endmodule

// ----- hw/rtl/sha_engine.sv -----
// Back end: block buffer, padding, 64-round compression and digest output.
module sha_engine import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_word,
    output logic [2:0]  o_index,
    output logic        o_last
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_PAD  = 6'b000010, S_LOAD = 6'b000100,
        S_RND  = 6'b001000, S_ADD  = 6'b010000, S_OUT  = 6'b100000
    } t_state;

    t_state       r_state;
    logic [31:0]  r_buf [16];  // block as big-endian words, one byte lane per write
    logic [5:0]   r_fill;
    logic [60:0]  r_total;
    logic [31:0]  r_h [8];
    logic [31:0]  r_v [8];
    logic [31:0]  r_w [16];
    logic [5:0]   r_rnd;
    logic [3:0]   r_ld;
    logic         r_final;  // compression belongs to end of message
    logic         r_lenok;  // length goes in the block being padded
    logic [2:0]   r_oidx;

    logic [63:0]  w_bits;
    logic [31:0]  w_wt, w_t1, w_t2, w_s0, w_s1, w_e, w_a;
    logic [7:0]   w_pb;

    assign o_ready = (r_state == S_IDLE);
    assign w_bits  = {r_total, 3'b000};
    assign o_valid = (r_state == S_OUT);
    assign o_word  = r_h[r_oidx];
    assign o_index = r_oidx;
    assign o_last  = (r_oidx == 3'd7);

    // padding byte at the current fill position
    always_comb begin
        if (r_fill < 6'd56 || !r_lenok) begin
            w_pb = 8'h00;
        end else begin
            w_pb = w_bits[8*(63-r_fill) +: 8];
        end
    end

    // schedule and round arithmetic
    always_comb begin
        w_s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        w_s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_wt = r_w[0];
        w_e  = r_v[4];
        w_a  = r_v[0];
        w_t1 = r_v[7] + (rotr(w_e, 6) ^ rotr(w_e, 11) ^ rotr(w_e, 25))
             + ((w_e & r_v[5]) ^ (~w_e & r_v[6])) + ROUND_K[r_rnd] + w_wt;
        w_t2 = (rotr(w_a, 2) ^ rotr(w_a, 13) ^ rotr(w_a, 22))
             + ((w_a & r_v[1]) ^ (w_a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // block buffer writes, earliest byte in the top lane
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <=
                (i_req.func == FUNC_BYTE) ? i_req.data : 8'h80;
        end else if (r_state == S_PAD) begin
            r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= w_pb;
        end
    end

    // schedule window: load 16 words, then slide one per round
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
            r_w[15] <= r_buf[r_ld];
        end else if (r_state == S_RND) begin
            for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
            r_w[15] <= r_w[0] + w_s0 + r_w[9] + w_s1;
        end
    end

    // control and hash state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_total <= '0;
            r_rnd   <= '0;
            r_ld    <= '0;
            r_final <= 1'b0;
            r_lenok <= 1'b0;
            r_oidx  <= '0;
            for (int k = 0; k < 8; k++) r_h[k] <= INIT_HASH[k];
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_fill <= r_fill + 1'b1;
                        r_ld   <= '0;
                        if (i_req.func == FUNC_BYTE) begin
                            r_total <= r_total + 1'b1;
                            r_final <= 1'b0;
                            if (r_fill == 6'd63) r_state <= S_LOAD;
                        end else begin
                            r_final <= 1'b1;
                            r_lenok <= (r_fill < 6'd56);
                            if (r_fill == 6'd63) r_state <= S_LOAD;
                            else r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_fill <= r_fill + 1'b1;
                    if (r_fill == 6'd63) r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_ld <= r_ld + 1'b1;
                    if (r_ld == 4'd15) begin
                        r_state <= S_RND;
                        r_rnd   <= '0;
                        for (int k = 0; k < 8; k++) r_v[k] <= r_h[k];
                    end
                end
                S_RND: begin
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    r_rnd  <= r_rnd + 1'b1;
                    if (r_rnd == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + r_v[k];
                    r_fill <= '0;
                    r_ld   <= '0;
                    if (!r_final) begin
                        r_state <= S_IDLE;
                    end else if (!r_lenok) begin
                        // second final block carries only zeros and length
                        r_lenok <= 1'b1;
                        r_state <= S_PAD;
                    end else begin
                        r_oidx  <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_oidx <= r_oidx + 1'b1;
                        if (r_oidx == 3'd7) begin
                            r_state <= S_IDLE;
                            r_final <= 1'b0;
                            r_lenok <= 1'b0;
                            r_total <= '0;
                            for (int k = 0; k < 8; k++) r_h[k] <= INIT_HASH[k];
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hw/rtl/sha256_stream_hasher.sv -----
// Top level of the streaming SHA-256 hasher.
// Usage:
//   Slave channel: one request per byte; tuser = func (0 byte, 1 end of
//   message), tdata = message byte.
//   Master channel: after end of message, eight digest words in tdata[31:0]
//   with the word index in tdata[34:32]; tlast marks the eighth word.
//   Requests enter a four-entry queue; the engine takes one byte per cycle
//   while gathering a block. A full block is loaded as 16 schedule words,
//   run through 64 rounds and added into the hash on the single shared round unit.
//   End of message pads at one byte per cycle, into a second block when the
//   length no longer fits, compresses, then shows the digest words one per
//   cycle while the master side is ready.
//   Reset returns to the initial hash values with an empty block.
//   A stall on the master side holds the current word; the queue keeps
//   accepting until it fills.
`include "sha256_stream_hasher_macros.svh"
module sha256_stream_hasher import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tuser,  // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast
);
    t_req        w_in_req, w_q_req;
    logic        w_q_valid, w_q_ready;
    logic [31:0] w_word;
    logic [2:0]  w_idx;

    assign w_in_req.func = s_axis_tuser;
    assign w_in_req.data = s_axis_tdata;

    sha_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_req(w_in_req),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_req(w_q_req));

    sha_engine u_engine (
        .i_clk, .i_rst_n,
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_req(w_q_req),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_word(w_word), .o_index(w_idx), .o_last(m_axis_tlast));

    assign m_axis_tdata = {5'b0, w_idx, w_word};

    `SHA_ASSERT_IMPL(a_last_idx, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[34:32] == 3'd7)
    `SHA_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
    `SHA_ASSERT_NEXT(a_end_out, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)
endmodule

// ----- dv/sha256_checker.sv -----
// Checker for the SHA-256 stream hasher: predicts digests from requests and compares words.
`timescale 1ns / 1ps
module sha256_checker import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] func
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // [31:0] digest_word, [34:32] word_index
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_words_due
);
    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    // Predicted hasher state
    logic [7:0]   msg_block [64];
    int           block_fill;
    logic [31:0]  chain [8];
    logic [60:0]  msg_bytes;
    t_digest_word digest_due [$];

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic restart_message();
        for (int i = 0; i < 8; i++) chain[i] = INIT_HASH[i];
        block_fill = 0;
        msg_bytes  = '0;
    endtask

    // One 64-round compression of msg_block into chain
    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wr, t1, t2, s0, s1;
        for (int k = 0; k < 16; k++)
            w[k] = {msg_block[4*k], msg_block[4*k+1], msg_block[4*k+2], msg_block[4*k+3]};
        for (int k = 0; k < 8; k++) v[k] = chain[k];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                wr = w[r];
            end else begin
                s0 = ror32(w[(r-15)&15], 7) ^ ror32(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
                s1 = ror32(w[(r-2)&15], 17) ^ ror32(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
                wr = w[r&15] + s0 + w[(r-7)&15] + s1;
                w[r&15] = wr;
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wr;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++) chain[k] += v[k];
        block_fill = 0;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        msg_block[block_fill] = b;
        block_fill++;
        msg_bytes++;
        if (block_fill == 64) compress_block();
    endtask

    // Padding, length field, final compression and digest words
    task automatic finish_message();
        t_digest_word dw;
        logic [63:0]  bit_len;
        bit_len = {msg_bytes, 3'b000};
        msg_block[block_fill] = 8'h80;
        block_fill++;
        if (block_fill > 56) begin
            while (block_fill < 64) begin
                msg_block[block_fill] = 8'h00;
                block_fill++;
            end
            compress_block();
        end
        while (block_fill < 56) begin
            msg_block[block_fill] = 8'h00;
            block_fill++;
        end
        for (int k = 0; k < 8; k++) msg_block[56+k] = bit_len[63-8*k -: 8];
        compress_block();
        for (int k = 0; k < 8; k++) begin
            dw.word  = chain[k];
            dw.index = k[2:0];
            dw.last  = (k == 7);
            digest_due.push_back(dw);
        end
        restart_message();
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_words_due  = 0;
        restart_message();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_message();
        end else begin
            // Digest word check against oldest expectation
            if (i_m_tvalid && i_m_tready) begin
                if (digest_due.size() == 0) begin
                    report("unexpected word", i_m_tdata[31:0], 32'h0);
                end else begin
                    if (i_m_tdata[31:0] != digest_due[0].word)
                        report("digest_word", i_m_tdata[31:0], digest_due[0].word);
                    if (i_m_tdata[34:32] != digest_due[0].index)
                        report("word_index", 32'(i_m_tdata[34:32]), 32'(digest_due[0].index));
                    if (i_m_tlast != digest_due[0].last)
                        report("last_word", 32'(i_m_tlast), 32'(digest_due[0].last));
                    void'(digest_due.pop_front());
                end
            end
            // Request into predictor
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == FUNC_END) finish_message();
                else absorb_byte(i_s_tdata);
            end
        end
        o_words_due = digest_due.size();
    end
endmodule

// ----- dv/testbench.sv -----
// Top of the SHA-256 stream hasher testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import sha_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tuser = FUNC_BYTE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count;
    int          words_due;
    int          items_sent;
    bit          calm_tail = 1'b0;
    int          sink_hold = 0;

    always #2 i_clk = ~i_clk;

    sha256_stream_hasher DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast));

    sha256_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tlast(m_axis_tlast),
        .o_fail_count(fail_count), .o_words_due(words_due));

    // Receiver stalls in short bursts
    always @(negedge i_clk) begin
        if (calm_tail || !i_rst_n) begin
            m_axis_tready <= i_rst_n;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            sink_hold <= $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // One request; called just after a falling edge
    task automatic send_req(input logic func, input logic [7:0] b);
        int gap;
        if (!calm_tail && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) send_req(FUNC_BYTE, 8'($urandom));
        send_req(FUNC_END, 8'($urandom));
    endtask

    task automatic drain_digests();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (words_due != 0) @(negedge i_clk);
    endtask

    initial begin
        int len;
        int pick;
        items_sent = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty message, one-byte extremes, short mixed message
        send_req(FUNC_END, 8'h00);
        send_req(FUNC_BYTE, 8'h00);
        send_req(FUNC_END, 8'hff);
        send_req(FUNC_BYTE, 8'hff);
        send_req(FUNC_END, 8'h00);
        send_req(FUNC_BYTE, 8'h61);
        send_req(FUNC_BYTE, 8'h62);
        send_req(FUNC_BYTE, 8'h63);
        send_req(FUNC_END, 8'h00);
        send_req(FUNC_END, 8'h55);
        for (int i = 0; i < 8; i++) send_req(FUNC_BYTE, 8'h01 << i);
        send_req(FUNC_END, 8'haa);

        // Sender holds off until every digest is out
        drain_digests();

        // Random messages, mostly short, padding boundaries often
        while (items_sent < 380) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) len = $urandom_range(0, 12);
            else if (pick == 5) begin
                case ($urandom_range(0, 5))
                    0: len = 55;
                    1: len = 56;
                    2: len = 57;
                    3: len = 63;
                    4: len = 64;
                    default: len = 65;
                endcase
            end
            else if (pick == 6) len = $urandom_range(0, 130);
            else len = $urandom_range(1, 40);
            // keep the total close to the planned item count
            if (len > 380 - items_sent) len = 380 - items_sent;
            if (items_sent > 300) calm_tail = 1'b1;
            send_message(len);
        end
        s_axis_tvalid <= 1'b0;
        calm_tail = 1'b1;
        @(negedge i_clk);
        while (words_due != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("** sha256_stream_hasher: PASSED **");
        end else begin
            $display("** sha256_stream_hasher: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("** sha256_stream_hasher: FAILED **");
        $finish;
    end
endmodule

// ----- sha256_stream_hasher.f -----
+incdir+hw/rtl
hw/rtl/sha_pkg.sv
hw/rtl/sha_front.sv
hw/rtl/sha_engine.sv
hw/rtl/sha256_stream_hasher.sv
dv/sha256_checker.sv
dv/testbench.sv
